>>> hw/rtl/plh_pkg.sv
// Package for the linear-probe hash table: payload structs, status and
// opcode codes, and the splitmix64 finalizer constants. No dependencies.
`default_nettype none
package plh_pkg;

	localparam logic [1:0] OP_GET     = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_NEXT    = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NULL      = 3'd3;
	localparam logic [2:0] ST_DONE      = 3'd4;

	localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
	localparam int MIX_SH1 = 30;
	localparam int MIX_SH2 = 27;
	localparam int MIX_SH3 = 31;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] entry_key;
		logic [31:0] entry_value;
		logic [10:0] entry_count;
	} rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/plh_stream_if.sv
// Valid/ready channel interface carrying one payload struct per transfer.
// Depends on nothing but the payload type given as a parameter.
`default_nettype none
interface plh_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/plh_hash.sv
// Iterative splitmix64 finalizer built around one shared 32x32 multiplier.
// Depends on plh_pkg.
`default_nettype none
module plh_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] key,
	output logic             done,
	output logic [63:0]      hash
);
	import plh_pkg::*;

	logic [3:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [63:0] m_q;
	logic [63:0] acc_q;
	logic [63:0] mul_c;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] acc_next;

	// Steps 2..4 form the first 64-bit product, steps 6..8 the second; each
	// product is built from three 32-bit partial products, the high one dropped.
	always_comb begin
		mul_c    = (step_q >= 4'd5) ? MIX_MUL2 : MIX_MUL1;
		op_a     = (step_q == 4'd3 || step_q == 4'd7) ? m_q[63:32] : m_q[31:0];
		op_b     = (step_q == 4'd4 || step_q == 4'd8) ? mul_c[63:32] : mul_c[31:0];
		prod     = 64'(op_a) * 64'(op_b);
		acc_next = acc_q + {prod[31:0], 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					step_q <= 4'd1;
				end
			end else if (step_q == 4'd8) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				step_q <= '0;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			x_q <= key + MIX_ADD;
		end else if (busy_q) begin
			case (step_q)
				4'd1: m_q <= x_q ^ (x_q >> MIX_SH1);
				4'd5: m_q <= x_q ^ (x_q >> MIX_SH2);
				4'd2, 4'd6: acc_q <= prod;
				4'd3, 4'd7: acc_q <= acc_next;
				4'd4, 4'd8: x_q <= acc_next;
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign hash = x_q ^ (x_q >> MIX_SH3);
endmodule
`default_nettype wire

>>> hw/rtl/linear_probe_hash_table.sv
// Linear-probe hash table, 64-bit keys to value handles, one operation at a time.
// Get and set hash the key after the request transfer, then probe slots for the result:
// the hash runs on one shared 32x32 multiplier and each slot read is registered.
// Restart and refused sets go straight to the result; next reads slots until one is occupied.
// A stalled result holds the next one and the request side closed. After reset a clearing
// pass empties the slots. Depends on plh_pkg, plh_stream_if, plh_hash.
`default_nettype none
module linear_probe_hash_table #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	plh_stream_if.sink   req,
	plh_stream_if.source rsp
);
	import plh_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int WORD_W = 1 + 64 + VW;
	localparam logic [IDX_W-1:0] MASK = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] HALF_C = CNT_W'(CAPACITY / 2);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PRD   = 3'd3;
	localparam logic [2:0] S_PCHK  = 3'd4;
	localparam logic [2:0] S_SRD   = 3'd5;
	localparam logic [2:0] S_SCHK  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	// Each slot word holds the occupied mark, the key and the value.
	logic [WORD_W-1:0] slot_mem [CAPACITY];
	logic [WORD_W-1:0] rd_q;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] probes_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cursor_q;
	logic [1:0]       op_q;
	logic [63:0]      key_q;
	logic [VW-1:0]    val_q;
	logic [2:0]       st_q;
	logic [63:0]      ekey_q;
	logic [VW-1:0]    eval_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             we;
	logic [IDX_W-1:0] wa;
	logic [WORD_W-1:0] wd;
	logic [IDX_W-1:0] ra;
	logic             hash_start;
	logic             hash_done;
	logic [63:0]      hash;
	logic             rd_occ;
	logic [63:0]      rd_key;
	logic [VW-1:0]    rd_val;
	logic [IDX_W-1:0] idx_eff;
	logic [CNT_W-1:0] probes_next;

	plh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.done   (hash_done),
		.hash   (hash)
	);

	assign rd_occ = rd_q[WORD_W-1];
	assign rd_key = rd_q[WORD_W-2 -: 64];
	assign rd_val = rd_q[VW-1:0];

	// A home slot past the end wraps to slot zero, as the probe walk does.
	assign idx_eff     = ({1'b0, idx_q} >= (IDX_W+1)'(CAPACITY)) ? '0 : idx_q;
	assign probes_next = probes_q + 1'b1;

	assign req.ready  = (state_q == S_IDLE);
	assign hash_start = (state_q == S_HASH) && (probes_q == '0) && !hash_done;

	// The only write port: the clearing pass, or a set that found its slot.
	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = {1'b1, key_q, val_q};
		ra = idx_eff;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (state_q == S_PCHK && op_q == OP_SET &&
		             (!rd_occ || rd_key == key_q)) begin
			we = 1'b1;
		end
		if (state_q == S_SRD) begin
			ra = cursor_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[wa] <= wd;
		end
		rd_q <= slot_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			probes_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new result is loaded when the register is empty or being taken.
			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						probes_q <= '0;
						if (req.data.opcode == OP_GET) begin
							state_q <= S_HASH;
						end else if (req.data.opcode == OP_SET) begin
							if (req.data.value[VW-1:0] == '0 || count_q >= HALF_C) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_HASH;
							end
						end else if (req.data.opcode == OP_RESTART) begin
							cursor_q <= '0;
							state_q  <= S_FIN;
						end else if (cursor_q >= CAP_C) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_HASH: begin
					// The probe counter flags that the hash was started.
					if (hash_start) begin
						probes_q <= CNT_W'(1);
					end
					if (hash_done) begin
						probes_q <= '0;
						state_q  <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (!rd_occ || rd_key == key_q) begin
						if (op_q == OP_SET && !rd_occ) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_FIN;
					end else if (probes_next == CAP_C) begin
						state_q <= S_FIN;
					end else begin
						probes_q <= probes_next;
						state_q  <= S_PRD;
					end
				end
				S_SRD: begin
					cursor_q <= cursor_q + 1'b1;
					state_q  <= S_SCHK;
				end
				S_SCHK: begin
					if (rd_occ || cursor_q >= CAP_C) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_FIN: begin
					// The result register frees up once the last one is taken.
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload side: latch the request, then the status and found entry.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q   <= req.data.opcode;
			key_q  <= req.data.key;
			val_q  <= req.data.value[VW-1:0];
			ekey_q <= '0;
			eval_q <= '0;
			if (req.data.opcode == OP_SET && req.data.value[VW-1:0] == '0) begin
				st_q <= ST_NULL;
			end else if (req.data.opcode == OP_SET && count_q >= HALF_C) begin
				st_q <= ST_FULL;
			end else if (req.data.opcode == OP_NEXT && cursor_q >= CAP_C) begin
				st_q <= ST_DONE;
			end else begin
				st_q <= ST_OK;
			end
		end
		if (state_q == S_HASH && hash_done) begin
			idx_q <= hash[IDX_W-1:0] & MASK;
		end
		if (state_q == S_PRD) begin
			idx_q <= idx_eff;
		end
		if (state_q == S_PCHK) begin
			if (rd_occ && rd_key == key_q) begin
				if (op_q == OP_GET) begin
					eval_q <= rd_val;
				end
			end else if (rd_occ) begin
				idx_q <= (idx_q + 1'b1) & MASK;
				if (probes_next == CAP_C) begin
					st_q <= (op_q == OP_SET) ? ST_FULL : ST_NOT_FOUND;
				end
			end else if (op_q == OP_GET) begin
				st_q <= ST_NOT_FOUND;
			end
		end
		if (state_q == S_SCHK) begin
			if (rd_occ) begin
				ekey_q <= rd_key;
				eval_q <= rd_val;
			end else if (cursor_q >= CAP_C) begin
				st_q <= ST_DONE;
			end
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_q.status      <= st_q;
			rsp_q.entry_key   <= ekey_q;
			rsp_q.entry_value <= 32'(eval_q);
			rsp_q.entry_count <= 11'(count_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
endmodule
`default_nettype wire

>>> hw/rtl/plh_checker.sv
// Port-level checks for the linear-probe hash table, bound to its top level.
// Depends on plh_pkg and linear_probe_hash_table.
`default_nettype none
module plh_checker #(
	parameter int CAPACITY = 1024
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire plh_pkg::rsp_t rsp_data
);
	import plh_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.entry_count <= 11'(CAPACITY / 2))
		else $error("stored count above half capacity");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status <= ST_DONE)
		else $error("status code out of range");

	a_empty_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
			rsp_data.entry_key == '0 && rsp_data.entry_value == '0)
		else $error("failed result carries an entry");
endmodule

bind linear_probe_hash_table plh_checker #(.CAPACITY(CAPACITY)) u_plh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the linear-probe hash table: directed and random
// get, set and iteration requests, checked against an in-bench table model.
// Depends on plh_pkg, plh_stream_if and the linear_probe_hash_table RTL.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import plh_pkg::*;

	localparam int SLOTS = 1024;

	// Scoreboard: holds a software copy of the table and the queue of
	// responses that the accepted requests are still owed.
	class hash_scoreboard;
		logic [63:0] slot_key[SLOTS];
		logic [31:0] slot_val[SLOTS];
		bit          slot_used[SLOTS];
		int          key_count;
		int          cursor;
		rsp_t        owed_q[$];
		int          errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			key_count = 0;
			cursor = 0;
			errors = 0;
		endfunction

		function logic [63:0] splitmix(logic [63:0] k);
			logic [63:0] x;
			x = k + MIX_ADD;
			x = (x ^ (x >> MIX_SH1)) * MIX_MUL1;
			x = (x ^ (x >> MIX_SH2)) * MIX_MUL2;
			return x ^ (x >> MIX_SH3);
		endfunction

		// Walks forward from the home slot; returns 1 when the key or a
		// free slot is found.
		function bit find_slot(logic [63:0] k, output int slot, output bit hit);
			int idx;
			idx = int'(splitmix(k) & 64'(SLOTS - 1));
			hit = 1'b0;
			slot = 0;
			for (int n = 0; n < SLOTS; n++) begin
				if (!slot_used[idx]) begin
					slot = idx;
					return 1'b1;
				end
				if (slot_key[idx] == k) begin
					slot = idx;
					hit = 1'b1;
					return 1'b1;
				end
				idx = (idx + 1) & (SLOTS - 1);
			end
			return 1'b0;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int   slot;
			bit   hit;
			e = '0;
			e.status = ST_OK;
			case (r.opcode)
				OP_GET: begin
					if (find_slot(r.key, slot, hit) && hit)
						e.entry_value = slot_val[slot];
					else
						e.status = ST_NOT_FOUND;
				end
				OP_SET: begin
					if (r.value == 0)
						e.status = ST_NULL;
					else if (key_count >= SLOTS / 2)
						e.status = ST_FULL;
					else if (!find_slot(r.key, slot, hit))
						e.status = ST_FULL;
					else begin
						if (!hit) key_count++;
						slot_key[slot] = r.key;
						slot_val[slot] = r.value;
						slot_used[slot] = 1'b1;
					end
				end
				OP_RESTART: cursor = 0;
				default: begin
					e.status = ST_DONE;
					while (cursor < SLOTS) begin
						cursor++;
						if (slot_used[cursor - 1]) begin
							e.entry_key = slot_key[cursor - 1];
							e.entry_value = slot_val[cursor - 1];
							e.status = ST_OK;
							break;
						end
					end
				end
			endcase
			e.entry_count = 11'(key_count);
			owed_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (owed_q.size() == 0) begin
				$error("response with none outstanding: status %0d", got.status);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.entry_key !== e.entry_key) begin
				$error("entry_key: expected %h, got %h", e.entry_key, got.entry_key);
				errors++;
			end
			if (got.entry_value !== e.entry_value) begin
				$error("entry_value: expected %h, got %h", e.entry_value, got.entry_value);
				errors++;
			end
			if (got.entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	plh_stream_if #(.T(req_t)) req_if ();
	plh_stream_if #(.T(rsp_t)) rsp_if ();

	linear_probe_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	hash_scoreboard table_model = new();

	// Keys that have been offered to set, so that gets and updates hit.
	logic [63:0] known_keys[$];
	// The response side reads this to start one long stall.
	bit          long_hold;
	// When set, the request side sends back to back for a while.
	bit          send_burst;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		long_hold = 1'b0;
		send_burst = 1'b0;
	end

	// Safety net: the slowest legal run is far shorter than this.
	initial begin
		#100ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offers one request and returns once its transfer has happened. Valid
	// is lowered only when a gap follows, so it never toggles within a step.
	task automatic send_request(req_t r);
		int gap;
		if ($urandom_range(9) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		table_model.note_request(r);
	endtask

	task automatic issue(logic [1:0] op, logic [63:0] k, logic [31:0] v);
		req_t r;
		r.opcode = op;
		r.key = k;
		r.value = v;
		if (op == OP_SET) known_keys.push_back(k);
		send_request(r);
	endtask

	// Holds the sender until every outstanding response has come back. The
	// request already transferred is withdrawn so that it is not taken twice.
	task automatic drain();
		req_if.valid <= 1'b0;
		while (table_model.owed_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_key(int known_pct);
		if (known_keys.size() != 0 && $urandom_range(99) < known_pct)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		if ($urandom_range(7) == 0) return 64'($urandom_range(15));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] pick_value();
		return ($urandom_range(19) == 0) ? 32'd0 : $urandom;
	endfunction

	// Response side: random stalls, quiet stretches, and one long hold-off
	// while the sender keeps offering so that the block backs up.
	initial begin
		int  gap;
		bit  quiet;
		quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(9) == 0) quiet = !quiet;
			gap = quiet ? 0 : $urandom_range(0, 17);
			if (long_hold) begin
				long_hold = 1'b0;
				gap = 400;
			end
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			table_model.check_response(rsp_if.data);
		end
	end

	initial begin
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table lookups, the extremes of key and
		// value, refused null sets, updates, and a scan past the end.
		issue(OP_GET, 64'h0, 32'h0);
		issue(OP_NEXT, 64'h0, 32'h0);
		issue(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_SET, 64'h0, 32'h1);
		issue(OP_SET, 64'h1234, 32'h0);
		issue(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		issue(OP_GET, 64'h0, 32'h0);
		issue(OP_GET, 64'h1234, 32'h0);
		issue(OP_SET, 64'h0, 32'h8000_0000);
		issue(OP_GET, 64'h0, 32'h0);
		issue(OP_RESTART, 64'h0, 32'h0);
		issue(OP_NEXT, 64'h0, 32'h0);
		// A set in the middle of a scan keeps the cursor where it is.
		issue(OP_SET, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA);
		repeat (4) issue(OP_NEXT, 64'h0, 32'h0);
		issue(OP_NEXT, 64'h0, 32'h0);
		issue(OP_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		repeat (4) issue(OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Back pressure: the response side stalls for a long stretch while
		// requests keep coming.
		long_hold = 1'b1;
		send_burst = 1'b1;

		// Random mix over a sparse table.
		for (int i = 0; i < 40; i++) begin
			r = $urandom_range(99);
			if (r < 35)
				issue(OP_SET, pick_key(30), pick_value());
			else if (r < 65)
				issue(OP_GET, pick_key(70), 32'h0);
			else if (r < 72)
				issue(OP_RESTART, {$urandom, $urandom}, $urandom);
			else
				issue(OP_NEXT, {$urandom, $urandom}, $urandom);
		end
		drain();

		// Fill to half load with fresh keys, with some gets mixed in, so
		// that probe chains grow and the full refusal is reached.
		while (table_model.key_count < SLOTS / 2) begin
			if ($urandom_range(9) == 0)
				issue(OP_GET, pick_key(80), 32'h0);
			else
				issue(OP_SET, {$urandom, $urandom}, $urandom | 32'h1);
		end
		drain();

		// At half load every set is refused, updates included.
		for (int i = 0; i < 40; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				issue(OP_SET, pick_key(50), pick_value());
			else if (r < 75)
				issue(OP_GET, pick_key(70), 32'h0);
			else if (r < 80)
				issue(OP_RESTART, 64'h0, 32'h0);
			else
				issue(OP_NEXT, {$urandom, $urandom}, $urandom);
		end

		drain();
		repeat (100) @(posedge clk);
		if (table_model.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
